// ===== sv/indexed_list_insert_erase_core_defines.svh =====
`ifndef INDEXED_LIST_INSERT_ERASE_CORE_DEFINES_SVH
`define INDEXED_LIST_INSERT_ERASE_CORE_DEFINES_SVH

// Assertion checked only while out of reset.
`define ILIE_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Assertion that must also hold while reset is applied.
`define ILIE_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/ilie_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ilie_pkg;

  localparam int unsigned KIND_W   = 3;
  localparam int unsigned POS_W    = 6;
  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned COUNT_W  = 7;
  localparam int unsigned IN_W     = 40;
  localparam int unsigned OUT_W    = 24;

  typedef enum logic [KIND_W-1:0] {
    KIND_APPEND = 3'd0,
    KIND_INSERT = 3'd1,
    KIND_ERASE  = 3'd2,
    KIND_DROP   = 3'd3,
    KIND_FIND   = 3'd4,
    KIND_CLEAR  = 3'd5
  } kind_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_EMPTY = 2'd2,
    ST_FULL  = 2'd3
  } status_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  typedef struct packed {
    logic load;
    logic shift_up;
    logic shift_down;
    logic compare;
  } cell_ctl_t;

endpackage

`default_nettype wire

// ===== sv/ilie_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ilie_cell
  import ilie_pkg::*;
(
  input  wire logic               clk_i,
  input  wire cell_ctl_t          ctl_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic [VALUE_W-1:0] prev_i,
  input  wire logic [VALUE_W-1:0] next_i,
  output logic      [VALUE_W-1:0] entry_o,
  output logic                    match_o
);

  logic [VALUE_W-1:0] entry_q;
  logic               match_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      entry_q <= value_i;
    end else if (ctl_i.shift_up) begin
      entry_q <= prev_i;
    end else if (ctl_i.shift_down) begin
      entry_q <= next_i;
    end
    if (ctl_i.compare) begin
      match_q <= (entry_q == value_i);
    end
  end

  assign entry_o = entry_q;
  assign match_o = match_q;

endmodule

`default_nettype wire

// ===== sv/indexed_list_insert_erase_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Ordered list of up to CAPACITY signed 32-bit words held in a row of cells, one word per
// cell. At acceptance each cell compares its word with the incoming value. In the execute
// state, once the output side is free, a cell loads the new word for append and insert,
// the cells shift up or down by one place for insert and erase, and the first match is
// encoded and the result is registered. A new request is taken in the cycle after the
// previous one left the execute state, so one request is handled at a time. There
// is no clearing pass after reset; the list is empty at once.

module indexed_list_insert_erase_core
  import ilie_pkg::*;
#(
  parameter int unsigned CAPACITY = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // [5:0] position, [37:6] value, [39:38] zero
  input  wire logic [IN_W-1:0]   s_axis_tdata_i,
  // [2:0] kind
  input  wire logic [KIND_W-1:0] s_axis_tuser_i,
  output logic                   m_axis_tvalid_o,
  input  wire logic              m_axis_tready_i,
  // [1:0] status, [2] found, [8:3] found_position, [15:9] count, [16] is_empty,
  // [23:17] zero
  output logic      [OUT_W-1:0]  m_axis_tdata_o
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned IW = $clog2(CAPACITY);
  localparam int unsigned LW = CW + POS_W;

  state_e              state_q, state_d;
  kind_e               kind_q;
  logic [POS_W-1:0]    pos_q;
  logic [VALUE_W-1:0]  value_q;
  logic [CW-1:0]       count_q, count_d;
  logic                m_valid_q;
  status_e             status_q, status_d;
  logic                found_q, found_d;
  logic [POS_W-1:0]    fpos_q, fpos_d;
  logic [COUNT_W-1:0]  cnt_out_q, cnt_out_d;
  logic                empty_q;

  logic                accept, out_free, adv;
  logic [LW-1:0]       pos_x, cnt_x;
  logic                pos_ok, not_full;
  logic                do_append, do_insert, do_erase;
  logic [VALUE_W-1:0]  cell_value;
  logic [VALUE_W-1:0]  entry [CAPACITY];
  logic [CAPACITY-1:0] match, hit, first;
  logic [IW-1:0]       fidx;
  logic [IW+POS_W-1:0] fidx_x;
  logic [CW+COUNT_W-1:0] cnt_x_out;

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free        = !m_valid_q || m_axis_tready_i;
  assign adv             = (state_q == S_EXEC) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (accept) state_d = S_EXEC;
      S_EXEC: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_e'(s_axis_tuser_i);
      pos_q   <= s_axis_tdata_i[POS_W-1:0];
      value_q <= s_axis_tdata_i[POS_W+VALUE_W-1:POS_W];
    end
  end

  assign pos_x    = {{CW{1'b0}}, pos_q};
  assign cnt_x    = {{POS_W{1'b0}}, count_q};
  assign pos_ok   = pos_x < cnt_x;
  assign not_full = cnt_x < LW'(CAPACITY);

  always_comb begin
    do_append = 1'b0;
    do_insert = 1'b0;
    do_erase  = 1'b0;
    status_d  = ST_OK;
    count_d   = count_q;
    unique case (kind_q)
      KIND_APPEND: begin
        if (not_full) begin
          do_append = 1'b1;
          count_d   = count_q + 1'b1;
        end else begin
          status_d = ST_FULL;
        end
      end
      KIND_INSERT: begin
        if (!pos_ok) begin
          status_d = ST_RANGE;
        end else if (!not_full) begin
          status_d = ST_FULL;
        end else begin
          do_insert = 1'b1;
          count_d   = count_q + 1'b1;
        end
      end
      KIND_ERASE: begin
        if (pos_ok) begin
          do_erase = 1'b1;
          count_d  = count_q - 1'b1;
        end else begin
          status_d = ST_RANGE;
        end
      end
      KIND_DROP: begin
        if (count_q == '0) begin
          status_d = ST_EMPTY;
        end else begin
          count_d = count_q - 1'b1;
        end
      end
      KIND_CLEAR: count_d = '0;
      default: ;
    endcase
  end

  assign cell_value = (state_q == S_IDLE) ? s_axis_tdata_i[POS_W+VALUE_W-1:POS_W] : value_q;

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_ctl_t          ctl;
    logic [VALUE_W-1:0] prev_w, next_w;

    assign ctl.load       = adv && ((do_append && (LW'(i) == cnt_x)) ||
                                    (do_insert && (LW'(i) == pos_x)));
    assign ctl.shift_up   = adv && do_insert && (LW'(i) > pos_x);
    assign ctl.shift_down = adv && do_erase && (LW'(i) >= pos_x);
    assign ctl.compare    = accept;

    if (i == 0) begin : g_first
      assign prev_w = entry[i];
    end else begin : g_prev
      assign prev_w = entry[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = entry[i];
    end else begin : g_next
      assign next_w = entry[i+1];
    end

    ilie_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .value_i (cell_value),
      .prev_i  (prev_w),
      .next_i  (next_w),
      .entry_o (entry[i]),
      .match_o (match[i])
    );

    assign hit[i] = match[i] && (LW'(i) < cnt_x);
  end

  assign first = hit & (~hit + CAPACITY'(1));

  always_comb begin
    fidx = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      if (first[i]) begin
        fidx = fidx | IW'(i);
      end
    end
  end

  assign fidx_x    = {{POS_W{1'b0}}, fidx};
  assign found_d   = (kind_q == KIND_FIND) && (|hit);
  assign fpos_d    = found_d ? fidx_x[POS_W-1:0] : '0;
  assign cnt_x_out = {{COUNT_W{1'b0}}, count_d};
  assign cnt_out_d = cnt_x_out[COUNT_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      m_valid_q <= 1'b0;
    end else if (adv) begin
      count_q   <= count_d;
      m_valid_q <= 1'b1;
    end else if (m_axis_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      status_q  <= status_d;
      found_q   <= found_d;
      fpos_q    <= fpos_d;
      cnt_out_q <= cnt_out_d;
      empty_q   <= (count_d == '0);
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {7'b0, empty_q, cnt_out_q, fpos_q, found_q, status_q};

endmodule

`default_nettype wire

// ===== sv/ilie_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "indexed_list_insert_erase_core_defines.svh"

module ilie_checker
  import ilie_pkg::*;
(
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              s_axis_tvalid_i,
  input wire logic              s_axis_tready_o,
  input wire logic [IN_W-1:0]   s_axis_tdata_i,
  input wire logic [KIND_W-1:0] s_axis_tuser_i,
  input wire logic              m_axis_tvalid_o,
  input wire logic              m_axis_tready_i,
  input wire logic [OUT_W-1:0]  m_axis_tdata_o
);

  logic unused_in;
  assign unused_in = ^{s_axis_tdata_i, s_axis_tuser_i};

  `ILIE_ASSERT(a_out_hold, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o), "Result changed while stalled.")
  `ILIE_ASSERT(a_one_per_two, clk_i, rst_ni, s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o, "Request taken while another is executing.")
  `ILIE_ASSERT(a_found_ok, clk_i, rst_ni, m_axis_tvalid_o && m_axis_tdata_o[2] |-> m_axis_tdata_o[1:0] == 2'd0, "Match reported with an error status.")
  `ILIE_ASSERT(a_fpos_zero, clk_i, rst_ni, m_axis_tvalid_o && !m_axis_tdata_o[2] |-> m_axis_tdata_o[8:3] == 6'd0, "Position reported without a match.")
  `ILIE_ASSERT_ALWAYS(a_empty_count, clk_i, m_axis_tvalid_o && m_axis_tdata_o[16] |-> m_axis_tdata_o[15:9] == 7'd0, "Empty list reported with entries.")

endmodule

bind indexed_list_insert_erase_core ilie_checker u_ilie_checker (.*);

`default_nettype wire
